FILE: design/qte_pkg.sv
`default_nettype none
package qte_pkg;

    // angle accumulator: radians scaled by 2^30, room for a turn of pi plus the cordic sum
    localparam int ZW = 34;
    localparam int ACC_FRAC = 30;
    localparam int TAB_LEN = 32;
    // square root datapath: radicand up to 2^60, root up to 2^30
    localparam int SQ_W = 62;
    localparam int ROOT_W = 31;
    localparam int ROOT_STEPS = 31;
    // rounded angle width after dropping 17 bits
    localparam int QW = ZW - 17;

    localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [QW-1:0] PI_Q13 = 17'sd25736;
    localparam logic signed [QW-1:0] HALF_PI_Q13 = 17'sd12868;

    function automatic logic [30:0] atan_entry(input int idx);
        logic [30:0] v;
        case (idx)
            0: v = 31'd843314857;
            1: v = 31'd497837829;
            2: v = 31'd263043837;
            3: v = 31'd133525159;
            4: v = 31'd67021687;
            5: v = 31'd33543516;
            6: v = 31'd16775851;
            7: v = 31'd8388437;
            8: v = 31'd4194283;
            9: v = 31'd2097149;
            default: begin
                if (idx >= 10 && idx < 31) begin
                    v = 31'd1 << (30 - idx);
                end else begin
                    v = 31'd0;
                end
            end
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: design/qte_sqrt_cell.sv
`default_nettype none
module qte_sqrt_cell
    import qte_pkg::*;
#(
    parameter int SHIFT = 0,
    parameter int PW = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [SQ_W-1:0]   i_n,
    input  wire logic [SQ_W-1:0]   i_r,
    input  wire logic [PW-1:0]     i_pass,
    output logic      [SQ_W-1:0]   o_n,
    output logic      [SQ_W-1:0]   o_r,
    output logic      [PW-1:0]     o_pass
);

    logic [SQ_W-1:0] bitv;
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] n_n;
    logic [SQ_W-1:0] n_r;
    logic [SQ_W-1:0] r_n;
    logic [SQ_W-1:0] r_r;
    logic [PW-1:0]   r_pass;

    assign bitv  = {{(SQ_W-1){1'b0}}, 1'b1} << (2 * SHIFT);
    assign trial = i_r + bitv;

    always_comb begin
        if (i_n >= trial) begin
            n_n = i_n - trial;
            n_r = (i_r >> 1) + bitv;
        end else begin
            n_n = i_n;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= n_n;
            r_r    <= n_r;
            r_pass <= i_pass;
        end
    end

    assign o_n    = r_n;
    assign o_r    = r_r;
    assign o_pass = r_pass;

endmodule
`default_nettype wire

FILE: design/qte_cordic_cell.sv
`default_nettype none
module qte_cordic_cell
    import qte_pkg::*;
#(
    parameter int STAGE = 0,
    parameter int CW = 39,
    parameter int PW = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [CW-1:0] i_x,
    input  wire logic signed [CW-1:0] i_y,
    input  wire logic signed [ZW-1:0] i_z,
    input  wire logic        [PW-1:0] i_pass,
    output logic signed      [CW-1:0] o_x,
    output logic signed      [CW-1:0] o_y,
    output logic signed      [ZW-1:0] o_z,
    output logic             [PW-1:0] o_pass
);

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] step;
    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic signed [ZW-1:0] n_z;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic        [PW-1:0] r_pass;

    assign dx   = i_y >>> STAGE;
    assign dy   = i_x >>> STAGE;
    assign step = $signed({{(ZW-31){1'b0}}, atan_entry(STAGE)});

    always_comb begin
        if (!i_y[CW-1]) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + step;
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_pass <= i_pass;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_pass = r_pass;

endmodule
`default_nettype wire

FILE: design/quaternion_to_euler_core.sv
`default_nettype none
// Quaternion (Q1.14) to Z-Y-X Euler angles (Q2.13 radians, pitch Q1.13), fully pipelined with no state:
// one quaternion transfer per cycle while the output is not held. The path is registers for the
// products, the sums, the fraction scaling and the squared sine, a 31-cell bit-per-cycle square
// root chain for the pitch cosine, a pre-rotation stage, CORDIC_STAGES vectoring cells for
// roll, yaw and pitch side by side, and the output register. A held output stalls the whole
// pipeline. pitch_clamped flags an asin argument of magnitude one or more.
module quaternion_to_euler_core
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS = 14
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_roll_angle,
    output logic signed [14:0]      o_pitch_angle,
    output logic signed [15:0]      o_yaw_angle,
    output logic                    o_pitch_clamped
);

    localparam int TWO_F = 2 * FRAC_BITS;
    localparam int SW  = (TWO_F + 2 > 35) ? TWO_F + 2 : 35;
    localparam int LSH = (ACC_FRAC > TWO_F) ? ACC_FRAC - TWO_F : 0;
    localparam int RSH = (TWO_F > ACC_FRAC) ? TWO_F - ACC_FRAC : 0;
    localparam int AW  = SW + LSH;
    localparam int CW  = AW + 2;
    localparam int PWQ = 5 * AW + 1;
    localparam int VL  = 4 + ROOT_STEPS + 1 + CORDIC_STAGES;
    localparam logic signed [SW-1:0] L_ONE = {{(SW-1){1'b0}}, 1'b1} << TWO_F;

    logic en;
    logic [VL-1:0] r_vld;
    logic r_out_vld;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = r_out_vld && i_stall;
    assign o_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[VL-2:0], i_valid};
            r_out_vld <= r_vld[VL-1];
        end
    end

    // products
    logic signed [31:0] r_pwx, r_pyz, r_pwz, r_pxy, r_pxx, r_pyy, r_pzz, r_pwy, r_pzx;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pwx <= i_quat_w * i_quat_x;
            r_pyz <= i_quat_y * i_quat_z;
            r_pwz <= i_quat_w * i_quat_z;
            r_pxy <= i_quat_x * i_quat_y;
            r_pxx <= i_quat_x * i_quat_x;
            r_pyy <= i_quat_y * i_quat_y;
            r_pzz <= i_quat_z * i_quat_z;
            r_pwy <= i_quat_w * i_quat_y;
            r_pzx <= i_quat_z * i_quat_x;
        end
    end

    // sums and clamp test on the exact value
    logic signed [SW-1:0] n_sr, n_cr, n_sy, n_cy, n_sp;
    logic signed [SW-1:0] r_sr, r_cr, r_sy, r_cy, r_sp;
    logic n_clamp, r_clamp;
    always_comb begin
        n_sr = (SW'(r_pwx) + SW'(r_pyz)) <<< 1;
        n_cr = L_ONE - ((SW'(r_pxx) + SW'(r_pyy)) <<< 1);
        n_sy = (SW'(r_pwz) + SW'(r_pxy)) <<< 1;
        n_cy = L_ONE - ((SW'(r_pyy) + SW'(r_pzz)) <<< 1);
        n_sp = (SW'(r_pwy) - SW'(r_pzx)) <<< 1;
        n_clamp = (n_sp >= L_ONE) || (n_sp <= -L_ONE);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr <= n_sr;
            r_cr <= n_cr;
            r_sy <= n_sy;
            r_cy <= n_cy;
            r_sp <= n_sp;
            r_clamp <= n_clamp;
        end
    end

    // bring to 30 fraction bits
    logic signed [AW-1:0] r_a_sr, r_a_cr, r_a_sy, r_a_cy, r_a_s;
    logic r_a_clamp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sr <= (AW'(r_sr) <<< LSH) >>> RSH;
            r_a_cr <= (AW'(r_cr) <<< LSH) >>> RSH;
            r_a_sy <= (AW'(r_sy) <<< LSH) >>> RSH;
            r_a_cy <= (AW'(r_cy) <<< LSH) >>> RSH;
            r_a_s  <= (AW'(r_sp) <<< LSH) >>> RSH;
            r_a_clamp <= r_clamp;
        end
    end

    // square of |s|, zero when clamped so the radicand stays in range
    logic signed [AW-1:0] s_neg;
    logic [ROOT_W-1:0] s_abs;
    logic [SQ_W-1:0] s_sq;
    logic [SQ_W-1:0] r_sq2;
    logic [PWQ-1:0] r_q_pass;
    assign s_neg = -r_a_s;
    always_comb begin
        if (r_a_clamp) begin
            s_abs = '0;
        end else if (r_a_s[AW-1]) begin
            s_abs = s_neg[ROOT_W-1:0];
        end else begin
            s_abs = r_a_s[ROOT_W-1:0];
        end
    end
    assign s_sq = s_abs * s_abs;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq2    <= s_sq;
            r_q_pass <= {r_a_clamp, r_a_s, r_a_cy, r_a_sy, r_a_cr, r_a_sr};
        end
    end

    // square root chain
    logic [SQ_W-1:0] q_n [ROOT_STEPS+1];
    logic [SQ_W-1:0] q_r [ROOT_STEPS+1];
    logic [PWQ-1:0]  q_p [ROOT_STEPS+1];
    assign q_n[0] = ({{(SQ_W-1){1'b0}}, 1'b1} << 60) - r_sq2;
    assign q_r[0] = '0;
    assign q_p[0] = r_q_pass;

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_sqrt
        qte_sqrt_cell #(
            .SHIFT(ROOT_STEPS - 1 - k),
            .PW(PWQ)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_n   (q_n[k]),
            .i_r   (q_r[k]),
            .i_pass(q_p[k]),
            .o_n   (q_n[k+1]),
            .o_r   (q_r[k+1]),
            .o_pass(q_p[k+1])
        );
    end

    // pre-rotation: 0 roll, 1 yaw, 2 pitch
    logic signed [CW-1:0] v_y [3];
    logic signed [CW-1:0] v_x [3];
    logic signed [CW-1:0] n_px [3];
    logic signed [CW-1:0] n_py [3];
    logic signed [ZW-1:0] n_pz [3];
    logic [1:0] n_pf [3];
    logic signed [CW-1:0] r_px [3];
    logic signed [CW-1:0] r_py [3];
    logic signed [ZW-1:0] r_pz [3];
    logic [1:0] r_pf [3];
    logic r_p_clamp, r_p_sneg;
    logic signed [AW-1:0] u_sr, u_cr, u_sy, u_cy, u_s;
    logic u_clamp;

    assign {u_clamp, u_s, u_cy, u_sy, u_cr, u_sr} = q_p[ROOT_STEPS];
    assign v_y[0] = CW'(u_sr);
    assign v_x[0] = CW'(u_cr);
    assign v_y[1] = CW'(u_sy);
    assign v_x[1] = CW'(u_cy);
    assign v_y[2] = CW'(u_s);
    assign v_x[2] = $signed({{(CW-ROOT_W){1'b0}}, q_r[ROOT_STEPS][ROOT_W-1:0]});

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            // flags: zero sine, negative cosine
            n_pf[v] = {(v_y[v] == '0), v_x[v][CW-1]};
            if (v_x[v][CW-1]) begin
                n_px[v] = -v_x[v];
                n_py[v] = -v_y[v];
                n_pz[v] = v_y[v][CW-1] ? -PI_Q30 : PI_Q30;
            end else begin
                n_px[v] = v_x[v];
                n_py[v] = v_y[v];
                n_pz[v] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px <= n_px;
            r_py <= n_py;
            r_pz <= n_pz;
            r_pf <= n_pf;
            r_p_clamp <= u_clamp;
            r_p_sneg  <= u_s[AW-1];
        end
    end

    // cordic chains
    logic signed [CW-1:0] c_x [3][CORDIC_STAGES+1];
    logic signed [CW-1:0] c_y [3][CORDIC_STAGES+1];
    logic signed [ZW-1:0] c_z [3][CORDIC_STAGES+1];
    logic [1:0] c_f [2][CORDIC_STAGES+1];
    logic [3:0] c_pf [CORDIC_STAGES+1];

    for (genvar v = 0; v < 3; v++) begin : g_head
        assign c_x[v][0] = r_px[v];
        assign c_y[v][0] = r_py[v];
        assign c_z[v][0] = r_pz[v];
    end
    assign c_f[0][0] = r_pf[0];
    assign c_f[1][0] = r_pf[1];
    assign c_pf[0]   = {r_p_clamp, r_p_sneg, r_pf[2]};

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
        for (genvar v = 0; v < 2; v++) begin : g_ry
            qte_cordic_cell #(.STAGE(s), .CW(CW), .PW(2)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_x   (c_x[v][s]),
                .i_y   (c_y[v][s]),
                .i_z   (c_z[v][s]),
                .i_pass(c_f[v][s]),
                .o_x   (c_x[v][s+1]),
                .o_y   (c_y[v][s+1]),
                .o_z   (c_z[v][s+1]),
                .o_pass(c_f[v][s+1])
            );
        end
        qte_cordic_cell #(.STAGE(s), .CW(CW), .PW(4)) u_pitch (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (c_x[2][s]),
            .i_y   (c_y[2][s]),
            .i_z   (c_z[2][s]),
            .i_pass(c_pf[s]),
            .o_x   (c_x[2][s+1]),
            .o_y   (c_y[2][s+1]),
            .o_z   (c_z[2][s+1]),
            .o_pass(c_pf[s+1])
        );
    end

    // round half up to Q3.13 and saturate
    logic [1:0] e_f [3];
    logic signed [ZW-1:0] e_a [3];
    logic signed [ZW-1:0] e_rnd [3];
    logic signed [QW-1:0] e_q [3];
    logic signed [QW-1:0] e_lim [3];
    logic signed [QW-1:0] e_sat [3];
    logic e_clamp, e_sneg;

    assign e_f[0] = c_f[0][CORDIC_STAGES];
    assign e_f[1] = c_f[1][CORDIC_STAGES];
    assign {e_clamp, e_sneg, e_f[2]} = c_pf[CORDIC_STAGES];
    assign e_lim[0] = PI_Q13;
    assign e_lim[1] = PI_Q13;
    assign e_lim[2] = HALF_PI_Q13;

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            if (e_f[v][1]) begin
                e_a[v] = e_f[v][0] ? PI_Q30 : '0;
            end else begin
                e_a[v] = c_z[v][CORDIC_STAGES];
            end
            e_rnd[v] = (e_a[v] + (ZW'(1) <<< 16)) >>> 17;
            e_q[v]   = e_rnd[v][QW-1:0];
            if (e_q[v] > e_lim[v]) begin
                e_sat[v] = e_lim[v];
            end else if (e_q[v] < -e_lim[v]) begin
                e_sat[v] = -e_lim[v];
            end else begin
                e_sat[v] = e_q[v];
            end
        end
        if (e_clamp) begin
            e_sat[2] = e_sneg ? -HALF_PI_Q13 : HALF_PI_Q13;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_roll_angle    <= e_sat[0][15:0];
            o_yaw_angle     <= e_sat[1][15:0];
            o_pitch_angle   <= e_sat[2][14:0];
            o_pitch_clamped <= e_clamp;
        end
    end

    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with no result held");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved while output held");

    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pitch_clamped) |->
        (o_pitch_angle == 15'sd12868 || o_pitch_angle == -15'sd12868))
        else $error("clamped pitch not at a pole");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_angle <= 16'sd25736 && o_roll_angle >= -16'sd25736))
        else $error("roll out of range");

endmodule
`default_nettype wire
